@@ src/ffra_pkg.sv @@
// Shared types and command codes for the first-fit range allocator.
// Used by ffra_ctrl, ffra_dpath and the top level; depends on nothing.
package ffra_pkg;

	localparam int CMD_W = 5;

	localparam logic [CMD_W-1:0] C_NONE        = 5'd0;
	localparam logic [CMD_W-1:0] C_TAKE        = 5'd1;
	localparam logic [CMD_W-1:0] C_LOAD        = 5'd2;
	localparam logic [CMD_W-1:0] C_SCAN_CLR    = 5'd3;
	localparam logic [CMD_W-1:0] C_RD_I        = 5'd4;
	localparam logic [CMD_W-1:0] C_RD_LAST     = 5'd5;
	localparam logic [CMD_W-1:0] C_ALLOC_HIT   = 5'd6;
	localparam logic [CMD_W-1:0] C_INC         = 5'd7;
	localparam logic [CMD_W-1:0] C_GROW_INIT   = 5'd8;
	localparam logic [CMD_W-1:0] C_GROW_STEP   = 5'd9;
	localparam logic [CMD_W-1:0] C_GROW_FAIL   = 5'd10;
	localparam logic [CMD_W-1:0] C_FULL        = 5'd11;
	localparam logic [CMD_W-1:0] C_GROW_COMMIT = 5'd12;
	localparam logic [CMD_W-1:0] C_RD_NEXT     = 5'd13;
	localparam logic [CMD_W-1:0] C_DROP_MV     = 5'd14;
	localparam logic [CMD_W-1:0] C_DROP_END    = 5'd15;
	localparam logic [CMD_W-1:0] C_FREE_FWD    = 5'd16;
	localparam logic [CMD_W-1:0] C_FREE_STOP   = 5'd17;
	localparam logic [CMD_W-1:0] C_FREE_END    = 5'd18;
	localparam logic [CMD_W-1:0] C_MERGE_BOTH  = 5'd19;
	localparam logic [CMD_W-1:0] C_MERGE_P     = 5'd20;
	localparam logic [CMD_W-1:0] C_MERGE_S     = 5'd21;
	localparam logic [CMD_W-1:0] C_SET_I_N     = 5'd22;
	localparam logic [CMD_W-1:0] C_RD_PREV     = 5'd23;
	localparam logic [CMD_W-1:0] C_UP_MV       = 5'd24;
	localparam logic [CMD_W-1:0] C_INS         = 5'd25;
	localparam logic [CMD_W-1:0] C_EMIT        = 5'd26;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] op;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic size_zero;
		logic free_skip;
		logic i_eq_n;
		logic fit;
		logic exact;
		logic adj;
		logic tail_ge;
		logic p_big;
		logic full;
		logic mp;
		logic ms;
		logic start_le;
		logic i_gt_pos;
		logic i1_lt_n;
		logic load_pend;
		logic out_free;
	} sts_t;

endpackage

@@ src/ffra_ctrl.sv @@
// Controller state machine of the range allocator.
// Depends on ffra_pkg; drives ffra_dpath through cmd_t, reads sts_t.
module ffra_ctrl
	import ffra_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LOAD  = 4'd1;
	localparam logic [3:0] S_CHK   = 4'd2;
	localparam logic [3:0] S_ARD   = 4'd3;
	localparam logic [3:0] S_ACMP  = 4'd4;
	localparam logic [3:0] S_GROW0 = 4'd5;
	localparam logic [3:0] S_GROW  = 4'd6;
	localparam logic [3:0] S_GCHK  = 4'd7;
	localparam logic [3:0] S_FRD   = 4'd8;
	localparam logic [3:0] S_FCMP  = 4'd9;
	localparam logic [3:0] S_FDEC  = 4'd10;
	localparam logic [3:0] S_UPCHK = 4'd11;
	localparam logic [3:0] S_UPWR  = 4'd12;
	localparam logic [3:0] S_DRD   = 4'd13;
	localparam logic [3:0] S_DWR   = 4'd14;
	localparam logic [3:0] S_FIN   = 4'd15;

	logic [3:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE) && !sts.load_pend;

	always_comb begin
		state_d = state_q;
		cmd.op = C_NONE;
		case (state_q)
			S_IDLE: begin
				if (sts.load_pend) begin
					state_d = S_LOAD;
				end else if (in_valid) begin
					cmd.op = C_TAKE;
					state_d = S_CHK;
				end
			end
			S_LOAD: begin
				cmd.op = C_LOAD;
				state_d = S_IDLE;
			end
			S_CHK: begin
				if (sts.size_zero || (sts.op == OP_FREE && sts.free_skip)) begin
					state_d = S_FIN;
				end else begin
					cmd.op = C_SCAN_CLR;
					state_d = (sts.op == OP_ALLOC) ? S_ARD : S_FRD;
				end
			end
			S_ARD: begin
				if (sts.i_eq_n) begin
					cmd.op = C_RD_LAST;
					state_d = S_GROW0;
				end else begin
					cmd.op = C_RD_I;
					state_d = S_ACMP;
				end
			end
			S_ACMP: begin
				if (sts.fit) begin
					cmd.op = C_ALLOC_HIT;
					state_d = sts.exact ? S_DRD : S_FIN;
				end else begin
					cmd.op = C_INC;
					state_d = S_ARD;
				end
			end
			S_GROW0: begin
				cmd.op = C_GROW_INIT;
				state_d = S_GROW;
			end
			S_GROW: begin
				if (sts.tail_ge) begin
					state_d = S_GCHK;
				end else if (sts.p_big) begin
					cmd.op = C_GROW_FAIL;
					state_d = S_FIN;
				end else begin
					cmd.op = C_GROW_STEP;
				end
			end
			S_GCHK: begin
				if (!sts.adj && sts.full) begin
					cmd.op = C_FULL;
				end else begin
					cmd.op = C_GROW_COMMIT;
				end
				state_d = S_FIN;
			end
			S_FRD: begin
				if (sts.i_eq_n) begin
					cmd.op = C_FREE_END;
					state_d = S_FDEC;
				end else begin
					cmd.op = C_RD_I;
					state_d = S_FCMP;
				end
			end
			S_FCMP: begin
				if (sts.start_le) begin
					cmd.op = C_FREE_FWD;
					state_d = S_FRD;
				end else begin
					cmd.op = C_FREE_STOP;
					state_d = S_FDEC;
				end
			end
			S_FDEC: begin
				if (sts.mp && sts.ms) begin
					cmd.op = C_MERGE_BOTH;
					state_d = S_DRD;
				end else if (sts.mp) begin
					cmd.op = C_MERGE_P;
					state_d = S_FIN;
				end else if (sts.ms) begin
					cmd.op = C_MERGE_S;
					state_d = S_FIN;
				end else if (sts.full) begin
					cmd.op = C_FULL;
					state_d = S_FIN;
				end else begin
					cmd.op = C_SET_I_N;
					state_d = S_UPCHK;
				end
			end
			S_UPCHK: begin
				if (sts.i_gt_pos) begin
					cmd.op = C_RD_PREV;
					state_d = S_UPWR;
				end else begin
					cmd.op = C_INS;
					state_d = S_FIN;
				end
			end
			S_UPWR: begin
				cmd.op = C_UP_MV;
				state_d = S_UPCHK;
			end
			S_DRD: begin
				if (sts.i1_lt_n) begin
					cmd.op = C_RD_NEXT;
					state_d = S_DWR;
				end else begin
					cmd.op = C_DROP_END;
					state_d = S_FIN;
				end
			end
			S_DWR: begin
				cmd.op = C_DROP_MV;
				state_d = S_DRD;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.op = C_EMIT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == C_TAKE |=> state_q == S_CHK)
		else $error("take did not start a request");
	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == C_EMIT |=> cmd.op != C_EMIT)
		else $error("result emitted twice");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |=> state_q == S_IDLE)
		else $error("load did not return to idle");
`endif

endmodule

@@ src/ffra_dpath.sv @@
// Datapath of the range allocator: free-list memories, counters, result register.
// Depends on ffra_pkg; commanded by ffra_ctrl.
module ffra_dpath
	import ffra_pkg::*;
#(
	parameter int FREE_SLOTS = 32,
	parameter int ADDR_BITS = 24,
	parameter int RESET_POOL = 1048576,
	parameter int IN_W = 56,
	parameter int OUT_W = 56
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [ADDR_BITS:0]   cfg_wdata,
	input  logic [IN_W-1:0]      in_data,
	input  logic                 in_user,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OUT_W-1:0]     out_data,
	input  cmd_t                 cmd,
	output sts_t                 sts
);

	localparam int A  = ADDR_BITS;
	localparam int IW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
	localparam int CW = $clog2(FREE_SLOTS + 1);
	localparam logic [A:0] MAX_POOL = {1'b1, {A{1'b0}}};
	localparam logic [A:0] HALF_POOL = {2'b01, {(A-1){1'b0}}};

	logic [A-1:0] start_mem [FREE_SLOTS];
	logic [A:0]   len_mem [FREE_SLOTS];

	logic [A-1:0]  rs_q, off_q, prev_start_q, cur_start_q, gnt_q;
	logic [A:0]    rl_q, size_q, pool_q, init_q, prev_len_q, cur_len_q, p_q;
	logic [A+1:0]  tail_q;
	logic [CW-1:0] n_q, i_q, pos_q;
	logic [1:0]    st_q;
	logic          op_q, adj_q, prev_ok_q, cur_ok_q, load_pend_q, out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic          we;
	logic [IW-1:0] waddr, raddr;
	logic [A-1:0]  ws;
	logic [A:0]    wl, clamp;
	logic [A+1:0]  off_end, prev_end, rs_end;
	logic [CW-1:0] n_dec, i_inc, i_dec, pos_dec;

	assign n_dec   = n_q - CW'(1);
	assign i_inc   = i_q + CW'(1);
	assign i_dec   = i_q - CW'(1);
	assign pos_dec = pos_q - CW'(1);
	assign off_end  = (A+2)'(off_q) + (A+2)'(size_q);
	assign prev_end = (A+2)'(prev_start_q) + (A+2)'(prev_len_q);
	assign rs_end   = (A+2)'(rs_q) + (A+2)'(rl_q);

	always_comb begin
		clamp = init_q;
		if (init_q == '0) begin
			clamp = (A+1)'(1);
		end else if (init_q > MAX_POOL) begin
			clamp = MAX_POOL;
		end
	end

	always_comb begin
		sts.op        = op_q;
		sts.size_zero = (size_q == '0);
		sts.free_skip = off_end > (A+2)'(pool_q);
		sts.i_eq_n    = (i_q == n_q);
		sts.fit       = (rl_q >= size_q);
		sts.exact     = (rl_q == size_q);
		sts.adj       = adj_q;
		sts.tail_ge   = (tail_q >= (A+2)'(size_q));
		sts.p_big     = (p_q > HALF_POOL);
		sts.full      = (n_q >= CW'(FREE_SLOTS));
		sts.mp        = prev_ok_q && (prev_end == (A+2)'(off_q));
		sts.ms        = cur_ok_q && (off_end == (A+2)'(cur_start_q));
		sts.start_le  = (rs_q <= off_q);
		sts.i_gt_pos  = (i_q > pos_q);
		sts.i1_lt_n   = (i_inc < n_q);
		sts.load_pend = load_pend_q;
		sts.out_free  = !out_valid_q || out_ready;
	end

	always_comb begin
		we = 1'b0;
		waddr = i_q[IW-1:0];
		raddr = i_q[IW-1:0];
		ws = rs_q;
		wl = rl_q;
		case (cmd.op)
			C_RD_LAST: raddr = n_dec[IW-1:0];
			C_RD_NEXT: raddr = i_inc[IW-1:0];
			C_RD_PREV: raddr = i_dec[IW-1:0];
			C_LOAD: begin
				we = 1'b1;
				waddr = '0;
				ws = '0;
				wl = clamp;
			end
			C_ALLOC_HIT: begin
				we = (rl_q != size_q);
				ws = rs_q + size_q[A-1:0];
				wl = rl_q - size_q;
			end
			C_GROW_COMMIT: begin
				we = (tail_q != (A+2)'(size_q));
				waddr = adj_q ? n_dec[IW-1:0] : n_q[IW-1:0];
				ws = cur_start_q + size_q[A-1:0];
				wl = tail_q[A:0] - size_q;
			end
			C_DROP_MV, C_UP_MV: we = 1'b1;
			C_MERGE_BOTH: begin
				we = 1'b1;
				waddr = pos_dec[IW-1:0];
				ws = prev_start_q;
				wl = prev_len_q + size_q + cur_len_q;
			end
			C_MERGE_P: begin
				we = 1'b1;
				waddr = pos_dec[IW-1:0];
				ws = prev_start_q;
				wl = prev_len_q + size_q;
			end
			C_MERGE_S: begin
				we = 1'b1;
				waddr = pos_q[IW-1:0];
				ws = off_q;
				wl = cur_len_q + size_q;
			end
			C_INS: begin
				we = 1'b1;
				waddr = pos_q[IW-1:0];
				ws = off_q;
				wl = size_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			start_mem[waddr] <= ws;
			len_mem[waddr] <= wl;
		end
		rs_q <= start_mem[raddr];
		rl_q <= len_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= CW'(1);
			i_q <= '0;
			pos_q <= '0;
			pool_q <= (A+1)'(RESET_POOL);
			init_q <= (A+1)'(RESET_POOL);
			load_pend_q <= 1'b1;
			out_valid_q <= 1'b0;
			prev_ok_q <= 1'b0;
			cur_ok_q <= 1'b0;
			adj_q <= 1'b0;
			op_q <= OP_ALLOC;
			st_q <= ST_OK;
		end else begin
			if (cmd.op == C_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				C_TAKE: begin
					op_q <= in_user;
					gnt_q <= '0;
					st_q <= ST_OK;
				end
				C_LOAD: begin
					n_q <= CW'(1);
					pool_q <= clamp;
				end
				C_SCAN_CLR: begin
					i_q <= '0;
					prev_ok_q <= 1'b0;
					cur_ok_q <= 1'b0;
				end
				C_ALLOC_HIT: gnt_q <= rs_q;
				C_INC, C_DROP_MV: i_q <= i_inc;
				C_GROW_INIT: begin
					adj_q <= (n_q != '0) && (rs_end == (A+2)'(pool_q));
					p_q <= pool_q;
					if ((n_q != '0) && (rs_end == (A+2)'(pool_q))) begin
						tail_q <= (A+2)'(rl_q);
						cur_start_q <= rs_q;
					end else begin
						tail_q <= '0;
						cur_start_q <= pool_q[A-1:0];
					end
				end
				C_GROW_STEP: begin
					tail_q <= tail_q + (A+2)'(p_q);
					p_q <= {p_q[A-1:0], 1'b0};
				end
				C_GROW_FAIL: st_q <= ST_NOSPACE;
				C_FULL: st_q <= ST_FULL;
				C_GROW_COMMIT: begin
					pool_q <= p_q;
					gnt_q <= cur_start_q;
					if (tail_q == (A+2)'(size_q)) begin
						if (adj_q) begin
							n_q <= n_dec;
						end
					end else if (!adj_q) begin
						n_q <= n_q + CW'(1);
					end
				end
				C_DROP_END: n_q <= n_dec;
				C_FREE_FWD: begin
					prev_start_q <= rs_q;
					prev_len_q <= rl_q;
					prev_ok_q <= 1'b1;
					i_q <= i_inc;
				end
				C_FREE_STOP: begin
					cur_start_q <= rs_q;
					cur_len_q <= rl_q;
					cur_ok_q <= 1'b1;
					pos_q <= i_q;
				end
				C_FREE_END: pos_q <= i_q;
				C_SET_I_N: i_q <= n_q;
				C_UP_MV: i_q <= i_dec;
				C_INS: n_q <= n_q + CW'(1);
				default: begin
				end
			endcase
			if (cfg_we) begin
				init_q <= cfg_wdata;
				load_pend_q <= 1'b1;
			end else if (cmd.op == C_LOAD) begin
				load_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == C_TAKE) begin
			off_q <= in_data[A-1:0];
			size_q <= in_data[2*A:A];
		end
		if (cmd.op == C_EMIT) begin
			out_data_q <= OUT_W'({pool_q, st_q, gnt_q});
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

`ifndef ASSERT_OFF
	a_n_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CW'(FREE_SLOTS))
		else $error("free list count over capacity");
	a_i_bound: assert property (@(posedge clk) disable iff (!arst_n)
		i_q <= CW'(FREE_SLOTS))
		else $error("scan index past list capacity");
	a_pool_nz: assert property (@(posedge clk) disable iff (!arst_n)
		pool_q != '0 && pool_q <= MAX_POOL)
		else $error("pool size out of range");
	a_load_n: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == C_LOAD |=> n_q == CW'(1))
		else $error("load did not reset list");
`endif

endmodule

@@ src/first_fit_range_allocator_unit.sv @@
// First-fit range allocator with coalescing free list, top level.
// Run time grows with each scanned entry, each shifted entry and each pool doubling.
// Throughput: one request at a time; input is ready only while the controller idles.
// Reset (arst_n, async low) and each config write reload a single free range:
// the input is not ready until that reload is done.
module first_fit_range_allocator_unit
	import ffra_pkg::*;
#(
	parameter int FREE_SLOTS = 32,
	parameter int ADDR_BITS = 24,
	parameter int RESET_POOL = 1048576
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [ADDR_BITS:0] cfg_wdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// range_offset, range_size
	input  logic [((2*ADDR_BITS+1+7)/8)*8-1:0] s_axis_tdata,
	// opcode
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// granted_offset, status, current_pool_size
	output logic [((2*ADDR_BITS+3+7)/8)*8-1:0] m_axis_tdata
);

	localparam int IN_W = ((2*ADDR_BITS+1+7)/8)*8;
	localparam int OUT_W = ((2*ADDR_BITS+3+7)/8)*8;

	cmd_t cmd;
	sts_t sts;

	ffra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ffra_dpath #(
		.FREE_SLOTS (FREE_SLOTS),
		.ADDR_BITS  (ADDR_BITS),
		.RESET_POOL (RESET_POOL),
		.IN_W       (IN_W),
		.OUT_W      (OUT_W)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
